/* sv/sgmd_pkg.sv */
// Shared types, codes and helpers for the stick gesture menu decoder.
package sgmd_pkg;

	// Field widths.
	localparam int unsigned ACTION_W   = 2;
	localparam int unsigned DUTY_W     = 16;
	localparam int unsigned CODE_W     = 4;
	localparam int unsigned FLICK_W    = 3;
	localparam int unsigned FRAME_W    = 8;
	localparam int unsigned CENTER_W   = 12;
	localparam int unsigned LEVEL_W    = 11;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 12;
	// Signed width for pulse-width compares: holds duty and center plus level.
	localparam int unsigned CMP_W      = 18;

	// Parameter defaults.
	localparam int unsigned MIN_DUTY_DEF       = 800;
	localparam int unsigned MAX_DUTY_DEF       = 2200;
	localparam int unsigned SPECIAL_FRAMES_DEF = 200;

	// Actions.
	localparam logic [ACTION_W-1:0] ACT_SAMPLE    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_TAKE_TRIG = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TAKE_REQ  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NOP       = 2'd3;

	// Trigger and request codes.
	localparam logic [CODE_W-1:0] TRIG_DIR_CHANGE = 4'd5;
	localparam logic [CODE_W-1:0] TRIG_FULL_RESET = 4'd12;
	localparam logic [CODE_W-1:0] REQ_RIGHT_BASE  = 4'd4;
	localparam logic [CODE_W-1:0] REQ_FULL_LEFT   = 4'd9;
	localparam logic [CODE_W-1:0] REQ_FULL_RIGHT  = 4'd10;
	localparam logic [CODE_W-1:0] REQ_SPECIAL     = 4'd11;
	localparam logic [FLICK_W-1:0] MAX_FLICKS     = 3'd4;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLICK_LEVEL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_BAND   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_SIDES    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLICK_FRAMES  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_LATCH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_LATCH    = 3'd7;

	typedef struct packed {
		logic [CENTER_W-1:0] center_width;
		logic [LEVEL_W-1:0]  flick_level;
		logic [LEVEL_W-1:0]  full_level;
		logic [LEVEL_W-1:0]  centre_band;
		logic                swap_sides;
		logic [FRAME_W-1:0]  flick_frames;
		logic [FRAME_W-1:0]  centre_latch_frames;
		logic [FRAME_W-1:0]  full_latch_frames;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		center_width:        12'd1500,
		flick_level:         11'd220,
		full_level:          11'd440,
		centre_band:         11'd80,
		swap_sides:          1'b0,
		flick_frames:        8'd2,
		centre_latch_frames: 8'd10,
		full_latch_frames:   8'd20
	};

	typedef struct packed {
		logic [FLICK_W-1:0] left_flicks;
		logic [FLICK_W-1:0] right_flicks;
		logic [FRAME_W-1:0] left_hold_frames;
		logic [FRAME_W-1:0] right_hold_frames;
		logic [FRAME_W-1:0] centred_frames;
		logic [FRAME_W-1:0] full_left_frames;
		logic [FRAME_W-1:0] full_right_frames;
		logic [FRAME_W-1:0] special_frames;
		logic [CODE_W-1:0]  pending_request;
		logic [CODE_W-1:0]  last_trigger;
		logic               full_latched;
	} state_t;

	typedef struct packed {
		logic [CODE_W-1:0] trigger_value;
		logic [CODE_W-1:0] request_code;
		logic              sample_used;
	} result_t;

	// Saturating increments.
	function automatic logic [FRAME_W-1:0] inc_frame(input logic [FRAME_W-1:0] v);
		return (v == '1) ? v : v + FRAME_W'(1);
	endfunction

	function automatic logic [FLICK_W-1:0] inc_flick(input logic [FLICK_W-1:0] v);
		return (v == '1) ? v : v + FLICK_W'(1);
	endfunction

endpackage

/* sv/sgmd_in_if.sv */
// Input channel: action and duty sample with valid/ready handshake.
interface sgmd_in_if;
	import sgmd_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [DUTY_W-1:0]   duty;

	modport source (output valid, output action, output duty, input ready);
	modport sink (input valid, input action, input duty, output ready);
endinterface

/* sv/sgmd_out_if.sv */
// Output channel: trigger value, request code and sample flag with valid/ready handshake.
interface sgmd_out_if;
	import sgmd_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] trigger_value;
	logic [CODE_W-1:0] request_code;
	logic              sample_used;

	modport source (output valid, output trigger_value, output request_code,
		output sample_used, input ready);
	modport sink (input valid, input trigger_value, input request_code,
		input sample_used, output ready);
endinterface

/* sv/stick_gesture_menu_decoder_unit.sv */
// Top level of the stick gesture menu decoder: registers, pipeline and handshakes.
//
// Turns remote-control pulse widths into menu gestures. Each input transaction
// is either a duty sample (action 0), a take of the trigger value (action 1) or
// a take of the pending request (action 2); action 3 reads both without change.
// Every transaction gives exactly one result transaction. Samples outside
// MIN_DUTY..MAX_DUTY leave the state alone and report sample_used 0. Left and
// right flicks are counted and turn into request codes 1-4 (left) or 5-8 (right)
// once the stick rests centred; long full deflection latches 9 or 10, a long
// special hold latches 11. Trigger value 5 marks a direction change and 12 a
// full reset after too many flicks. The datapath is one input register, one
// block of compare-and-count logic and one result register: an accepted transaction
// passes from the input register into the result register, and one transaction is
// accepted per cycle as long as results are taken. The result register stalls
// on a low out_ch.ready, and the input register then holds one more transaction.
// Write configuration registers through cfg_we/cfg_index/cfg_data only while idle.
module stick_gesture_menu_decoder_unit #(
	parameter int unsigned MIN_DUTY       = sgmd_pkg::MIN_DUTY_DEF,
	parameter int unsigned MAX_DUTY       = sgmd_pkg::MAX_DUTY_DEF,
	parameter int unsigned SPECIAL_FRAMES = sgmd_pkg::SPECIAL_FRAMES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sgmd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sgmd_pkg::CFG_DATA_W-1:0]    cfg_data,
	sgmd_in_if.sink                            in_ch,
	sgmd_out_if.source                         out_ch
);
	import sgmd_pkg::*;

	cfg_t                cfg_q;
	state_t              st_q;
	state_t              st_next;
	result_t             res_next;

	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [DUTY_W-1:0]   duty_s1;

	logic                valid_s2;
	result_t             res_s2;

	logic                in_fire;
	logic                advance;

	// Result stage moves when empty or when its transaction is taken.
	assign advance     = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;
	assign in_fire     = in_ch.valid && in_ch.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_WIDTH: cfg_q.center_width        <= cfg_data[CENTER_W-1:0];
				REG_FLICK_LEVEL:  cfg_q.flick_level         <= cfg_data[LEVEL_W-1:0];
				REG_FULL_LEVEL:   cfg_q.full_level          <= cfg_data[LEVEL_W-1:0];
				REG_CENTRE_BAND:  cfg_q.centre_band         <= cfg_data[LEVEL_W-1:0];
				REG_SWAP_SIDES:   cfg_q.swap_sides          <= cfg_data[0];
				REG_FLICK_FRAMES: cfg_q.flick_frames        <= cfg_data[FRAME_W-1:0];
				REG_CENTRE_LATCH: cfg_q.centre_latch_frames <= cfg_data[FRAME_W-1:0];
				REG_FULL_LATCH:   cfg_q.full_latch_frames   <= cfg_data[FRAME_W-1:0];
			endcase
		end
	end

	// Input register: hold while the result stage is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1 <= in_ch.action;
			duty_s1   <= in_ch.duty;
		end
	end

	sgmd_step #(
		.MIN_DUTY       (MIN_DUTY),
		.MAX_DUTY       (MAX_DUTY),
		.SPECIAL_FRAMES (SPECIAL_FRAMES)
	) u_step (
		.cfg    (cfg_q),
		.cur    (st_q),
		.action (action_s1),
		.duty   (duty_s1),
		.nxt    (st_next),
		.res    (res_next)
	);

	// Gesture state advances together with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) st_q <= st_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) res_s2 <= res_next;
	end

	assign out_ch.valid         = valid_s2;
	assign out_ch.trigger_value = res_s2.trigger_value;
	assign out_ch.request_code  = res_s2.request_code;
	assign out_ch.sample_used   = res_s2.sample_used;

endmodule

/* sv/sgmd_step.sv */
// Next-state and result logic for one transaction of the gesture decoder.
module sgmd_step #(
	parameter int unsigned MIN_DUTY       = sgmd_pkg::MIN_DUTY_DEF,
	parameter int unsigned MAX_DUTY       = sgmd_pkg::MAX_DUTY_DEF,
	parameter int unsigned SPECIAL_FRAMES = sgmd_pkg::SPECIAL_FRAMES_DEF
) (
	input  sgmd_pkg::cfg_t                  cfg,
	input  sgmd_pkg::state_t                cur,
	input  logic [sgmd_pkg::ACTION_W-1:0]   action,
	input  logic [sgmd_pkg::DUTY_W-1:0]     duty,
	output sgmd_pkg::state_t                nxt,
	output sgmd_pkg::result_t               res
);
	import sgmd_pkg::*;

	logic                    in_window;
	logic signed [CMP_W-1:0] d, c, fl, fu, cb;
	state_t                  s;

	assign in_window = ({1'b0, duty} >= (DUTY_W+1)'(MIN_DUTY)) &&
		({1'b0, duty} <= (DUTY_W+1)'(MAX_DUTY));

	assign d  = signed'(CMP_W'(duty));
	assign c  = signed'(CMP_W'(cfg.center_width));
	assign fl = signed'(CMP_W'(cfg.flick_level));
	assign fu = signed'(CMP_W'(cfg.full_level));
	assign cb = signed'(CMP_W'(cfg.centre_band));

	// Sample update, in the same order of decisions as the gesture rules.
	always_comb begin
		s = cur;

		// Hold and centre classification.
		if (d < c - fl) begin
			if (cfg.swap_sides) s.right_hold_frames = inc_frame(s.right_hold_frames);
			else s.left_hold_frames = inc_frame(s.left_hold_frames);
		end else if (d > c + fl) begin
			if (cfg.swap_sides) s.left_hold_frames = inc_frame(s.left_hold_frames);
			else s.right_hold_frames = inc_frame(s.right_hold_frames);
		end else if (d < c + cb && d > c - cb) begin
			s.centred_frames    = inc_frame(s.centred_frames);
			s.left_hold_frames  = '0;
			s.right_hold_frames = '0;
			s.full_left_frames  = '0;
			s.full_right_frames = '0;
			s.full_latched      = 1'b0;
			s.special_frames    = '0;
		end

		// Full deflection; the special direction is full to the logical right.
		if ((d < c - fu && !cfg.swap_sides) || (d > c + fu && cfg.swap_sides)) begin
			s.full_left_frames = inc_frame(s.full_left_frames);
		end else if (d < c - fu || d > c + fu) begin
			s.full_right_frames = inc_frame(s.full_right_frames);
			s.special_frames    = inc_frame(s.special_frames);
		end

		// Count a flick once the stick returns through centre.
		if (s.left_hold_frames > cfg.flick_frames && s.centred_frames != '0) begin
			s.left_flicks    = inc_flick(s.left_flicks);
			s.last_trigger   = CODE_W'(s.left_flicks);
			s.centred_frames = '0;
		end else if (s.right_hold_frames > cfg.flick_frames && s.centred_frames != '0) begin
			s.right_flicks   = inc_flick(s.right_flicks);
			s.last_trigger   = CODE_W'(s.right_flicks);
			s.centred_frames = '0;
		end

		// Direction change: drop both counts.
		if ((s.left_flicks != '0 && s.right_flicks != '0) ||
			(s.left_hold_frames != '0 && s.right_hold_frames != '0)) begin
			s.left_flicks       = '0;
			s.right_flicks      = '0;
			s.last_trigger      = TRIG_DIR_CHANGE;
			s.left_hold_frames  = '0;
			s.right_hold_frames = '0;
			s.centred_frames    = '0;
		end

		// Latch a request.
		if (s.centred_frames > cfg.centre_latch_frames) begin
			if (s.right_flicks != '0)
				s.pending_request = REQ_RIGHT_BASE + CODE_W'(s.right_flicks);
			else
				s.pending_request = CODE_W'(s.left_flicks);
			s.left_flicks  = '0;
			s.right_flicks = '0;
		end else if (s.full_left_frames > cfg.full_latch_frames && !s.full_latched) begin
			s.pending_request = REQ_FULL_LEFT;
			s.left_flicks     = '0;
			s.right_flicks    = '0;
			s.full_latched    = 1'b1;
		end else if (s.full_right_frames > cfg.full_latch_frames && !s.full_latched) begin
			s.pending_request = REQ_FULL_RIGHT;
			s.left_flicks     = '0;
			s.right_flicks    = '0;
			s.full_latched    = 1'b1;
		end else if (s.special_frames > FRAME_W'(SPECIAL_FRAMES)) begin
			s.special_frames  = '0;
			s.pending_request = REQ_SPECIAL;
		end else if (s.left_flicks > MAX_FLICKS || s.right_flicks > MAX_FLICKS) begin
			s              = '0;
			s.last_trigger = TRIG_FULL_RESET;
		end
	end

	// Pick the action; takes report the value before clearing.
	always_comb begin
		nxt               = cur;
		res.trigger_value = cur.last_trigger;
		res.request_code  = cur.pending_request;
		res.sample_used   = 1'b0;
		unique case (action)
			ACT_SAMPLE: begin
				if (in_window) begin
					nxt               = s;
					res.trigger_value = s.last_trigger;
					res.request_code  = s.pending_request;
					res.sample_used   = 1'b1;
				end
			end
			ACT_TAKE_TRIG: nxt.last_trigger = '0;
			ACT_TAKE_REQ:  nxt.pending_request = '0;
			ACT_NOP: ;
		endcase
	end

endmodule
